// ----- hw/rtl/ifc_pkg.sv -----
`default_nettype none
package ifc_pkg;

  localparam int unsigned OpWidth = 4;
  localparam int unsigned DataWidth = 64;

  typedef enum logic [3:0] {
    OP_I32_I8   = 4'd0,
    OP_I32_I16  = 4'd1,
    OP_I32_I64  = 4'd2,
    OP_I32_F32  = 4'd3,
    OP_I32_F64  = 4'd4,
    OP_I64_I32  = 4'd5,
    OP_I64_F32  = 4'd6,
    OP_I64_F64  = 4'd7,
    OP_F32_I32  = 4'd8,
    OP_F32_I64  = 4'd9,
    OP_F32_F64  = 4'd10,
    OP_F64_I32  = 4'd11,
    OP_F64_I64  = 4'd12,
    OP_F64_F32  = 4'd13
  } op_t;

  // per-item control: opcode and wide flag
  typedef struct packed {
    logic [3:0] op;
    logic       wide;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ifc_if.sv -----
`default_nettype none
interface ifc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [63:0] operand;
  modport source (output valid, output opcode, output operand, input ready);
  modport sink (input valid, input opcode, input operand, output ready);
endinterface

interface ifc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        result_is_wide;
  modport source (output valid, output result, output result_is_wide, input ready);
  modport sink (input valid, input result, input result_is_wide, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ifc_lzc.sv -----
`default_nettype none
// position of the highest set bit of a 64-bit word, two levels of 8-way search
module ifc_lzc (
  input  wire logic [63:0] val,
  output logic      [5:0]  pos
);
  logic [7:0] grp_nz;
  logic [2:0] hi_g;
  logic [7:0] byte_v;
  logic [2:0] hi_b;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |val[g*8 +: 8];
    end
    hi_g = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) hi_g = 3'(g);
    end
    byte_v = val[{hi_g, 3'b000} +: 8];
    hi_b = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_v[b]) hi_b = 3'(b);
    end
    pos = {hi_g, hi_b};
  end
endmodule
`default_nettype wire

// ----- hw/rtl/int_float_conversion_unit.sv -----
`default_nettype none
// channel | dir | payload                  | handshake
// in      | in  | opcode[3:0] operand[63:0] | in.valid / in.ready
// out     | out | result[63:0] result_is_wide | out.valid / out.ready
// four register stages: decode/magnitude, normalize shift, round, pack
// one word per cycle sustained while the output accepts results
// the normalize shift and the rounding increment set the stage depth
// rst_n clears the stage valid bits only; a stall at the output holds every stage
module int_float_conversion_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ifc_in_if.sink    in_ch,
  ifc_out_if.source out_ch
);
  // s1: unpack into sign, magnitude (sig), binary exponent of bit 0 (e2)
  // kind: 0 pass or special (already final), 1 to-float, 2 to-int
  localparam logic [1:0] K_PASS = 2'd0, K_FLT = 2'd1, K_INT = 2'd2;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  assign adv = !v4_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1 ----------------
  logic [3:0]  op_i;
  logic [63:0] x;
  logic [31:0] lo;
  assign op_i = in_ch.opcode;
  assign x = in_ch.operand;
  assign lo = x[31:0];

  logic [1:0]  k_nxt;
  logic        neg_nxt, wide_nxt, dst_dbl_nxt, nbits64_nxt;
  logic [63:0] sig_nxt, fin_nxt;
  logic signed [12:0] e2_nxt;

  logic [1:0]  k1_r;
  logic        neg1_r, wide1_r, dbl1_r, n64_1_r;
  logic [63:0] sig1_r, fin1_r;
  logic signed [12:0] e21_r;

  always_comb begin
    logic        sd, nn;
    logic [10:0] ex;
    logic [51:0] fr;
    logic        s;
    k_nxt = K_PASS; neg_nxt = 1'b0; wide_nxt = 1'b0; dst_dbl_nxt = 1'b0;
    nbits64_nxt = 1'b0; sig_nxt = '0; fin_nxt = '0; e2_nxt = '0;
    sd = 1'b0; ex = '0; fr = '0; s = 1'b0; nn = 1'b0;
    case (op_i)
      ifc_pkg::OP_I32_I8:  fin_nxt = {32'd0, {24{lo[7]}}, lo[7:0]};
      ifc_pkg::OP_I32_I16: fin_nxt = {32'd0, {16{lo[15]}}, lo[15:0]};
      ifc_pkg::OP_I32_I64: begin fin_nxt = {{32{lo[31]}}, lo}; wide_nxt = 1'b1; end
      ifc_pkg::OP_I64_I32: fin_nxt = {32'd0, lo};
      ifc_pkg::OP_I32_F32, ifc_pkg::OP_I32_F64: begin
        k_nxt = K_FLT; neg_nxt = lo[31];
        sig_nxt = {32'd0, lo[31] ? 32'(-lo) : lo};
        dst_dbl_nxt = (op_i == ifc_pkg::OP_I32_F64); wide_nxt = dst_dbl_nxt;
      end
      ifc_pkg::OP_I64_F32, ifc_pkg::OP_I64_F64: begin
        k_nxt = K_FLT; neg_nxt = x[63];
        sig_nxt = x[63] ? -x : x;
        dst_dbl_nxt = (op_i == ifc_pkg::OP_I64_F64); wide_nxt = dst_dbl_nxt;
      end
      ifc_pkg::OP_F32_I32, ifc_pkg::OP_F32_I64, ifc_pkg::OP_F32_F64,
      ifc_pkg::OP_F64_I32, ifc_pkg::OP_F64_I64, ifc_pkg::OP_F64_F32: begin
        sd = (op_i == ifc_pkg::OP_F64_I32) || (op_i == ifc_pkg::OP_F64_I64) ||
             (op_i == ifc_pkg::OP_F64_F32);
        if (sd) begin
          s = x[63]; ex = x[62:52]; fr = x[51:0];
        end else begin
          s = lo[31]; ex = {3'd0, lo[30:23]}; fr = {29'd0, lo[22:0]};
        end
        neg_nxt = s;
        nn = sd ? (ex == 11'h7ff) : (ex == 11'h0ff);
        if (ex == 11'd0) begin
          sig_nxt = {12'd0, fr};
          e2_nxt = sd ? -13'sd1074 : -13'sd149;
        end else begin
          sig_nxt = sd ? {11'd0, 1'b1, fr} : {40'd0, 1'b1, fr[22:0]};
          e2_nxt = sd ? 13'($signed({2'b0, ex}) - 13'sd1075)
                      : 13'($signed({2'b0, ex}) - 13'sd150);
        end
        if (op_i == ifc_pkg::OP_F32_F64 || op_i == ifc_pkg::OP_F64_F32) begin
          dst_dbl_nxt = !sd; wide_nxt = !sd; k_nxt = K_FLT;
          if (nn) begin
            k_nxt = K_PASS;
            if (sd) fin_nxt = {32'd0, s, 8'hff, (fr != 0), fr[50:29]} ;
            else fin_nxt = {s, 11'h7ff, (fr != 0), fr[21:0], 29'd0};
          end else if (sig_nxt == 0) begin
            k_nxt = K_PASS;
            fin_nxt = sd ? {32'd0, s, 31'd0} : {s, 63'd0};
          end
        end else begin
          nbits64_nxt = (op_i == ifc_pkg::OP_F32_I64) || (op_i == ifc_pkg::OP_F64_I64);
          wide_nxt = nbits64_nxt;
          k_nxt = K_INT;
          if (nn) begin
            k_nxt = K_PASS;
            fin_nxt = nbits64_nxt ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
    if (adv) begin
      k1_r <= k_nxt; neg1_r <= neg_nxt; wide1_r <= wide_nxt; dbl1_r <= dst_dbl_nxt;
      n64_1_r <= nbits64_nxt; sig1_r <= sig_nxt; fin1_r <= fin_nxt; e21_r <= e2_nxt;
    end
  end

  // ---------------- stage 2: leading one, shift amounts ----------------
  logic [5:0] p;
  ifc_lzc u_lzc (.val(sig1_r), .pos(p));

  // to-float: sh = q - e2 with q = max(e, 1-bias) - fb, e = p + e2
  // to-int: left or right shift by e2
  logic signed [13:0] e_s, q_s, sh_s;
  logic [63:0] mag_nxt;
  logic        ovf_nxt;

  always_comb begin
    logic signed [13:0] emin, fb;
    logic [5:0] shl;
    logic [127:0] wide_sh;
    emin = dbl1_r ? -14'sd1022 : -14'sd126;
    fb = dbl1_r ? 14'sd52 : 14'sd23;
    e_s = 14'($signed({8'd0, p})) + 14'(e21_r);
    q_s = ((e_s > emin) ? e_s : emin) - fb;
    sh_s = q_s - 14'(e21_r);
    // integer path: magnitude limited to 64 bits
    mag_nxt = '0; ovf_nxt = 1'b0; shl = 6'(e21_r); wide_sh = '0;
    if (e21_r >= 0) begin
      if (e21_r >= 13'sd64) ovf_nxt = (sig1_r != 0);
      else begin
        wide_sh = {64'd0, sig1_r} << shl;
        ovf_nxt = (wide_sh[127:64] != 0);
        mag_nxt = wide_sh[63:0];
      end
    end else if (e21_r > -13'sd64) begin
      mag_nxt = sig1_r >> 6'(-e21_r);
    end
  end

  logic [1:0]  k2_r;
  logic        neg2_r, wide2_r, dbl2_r, n64_2_r, ovf2_r;
  logic [63:0] sig2_r, fin2_r, mag2_r;
  logic signed [13:0] q2_r, sh2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      k2_r <= k1_r; neg2_r <= neg1_r; wide2_r <= wide1_r; dbl2_r <= dbl1_r;
      n64_2_r <= n64_1_r; sig2_r <= sig1_r; fin2_r <= fin1_r; mag2_r <= mag_nxt;
      ovf2_r <= ovf_nxt; q2_r <= q_s; sh2_r <= sh_s;
    end
  end

  // ---------------- stage 3: shift and round ----------------
  logic [63:0] keep_nxt;
  logic [63:0] ires_nxt;

  always_comb begin
    logic [6:0]  sa;
    logic [63:0] msk, rem, half, kp;
    logic [63:0] lim, mn, m;
    sa = '0; msk = '0; rem = '0; half = '0; kp = '0;
    if (sh2_r <= 0) begin
      kp = sig2_r << 6'(-sh2_r);
    end else if (sh2_r >= 14'sd65) begin
      kp = '0;
    end else if (sh2_r == 14'sd64) begin
      kp = {63'd0, sig2_r > {1'b1, 63'd0}};
    end else begin
      sa = 7'(sh2_r);
      msk = (64'd1 << sa[5:0]) - 64'd1;
      rem = sig2_r & msk;
      half = 64'd1 << (sa[5:0] - 6'd1);
      kp = sig2_r >> sa[5:0];
      if (rem > half || (rem == half && kp[0])) kp = kp + 64'd1;
    end
    keep_nxt = kp;
    // integer path
    mn = n64_2_r ? {1'b1, 63'd0} : 64'h0000_0000_8000_0000;
    lim = neg2_r ? mn : mn - 64'd1;
    m = mag2_r;
    if (ovf2_r || m > lim) ires_nxt = mn;
    else begin
      ires_nxt = neg2_r ? -m : m;
      if (!n64_2_r) ires_nxt = {32'd0, ires_nxt[31:0]};
    end
  end

  logic [1:0]  k3_r;
  logic        neg3_r, wide3_r, dbl3_r;
  logic [63:0] fin3_r, keep3_r;
  logic signed [13:0] q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      k3_r <= k2_r; neg3_r <= neg2_r; wide3_r <= wide2_r; dbl3_r <= dbl2_r;
      fin3_r <= (k2_r == K_INT) ? ires_nxt : fin2_r;
      keep3_r <= keep_nxt; q3_r <= q2_r;
    end
  end

  // ---------------- stage 4: pack ----------------
  logic [63:0] res_nxt;

  always_comb begin
    logic [63:0] kp, mg;
    logic signed [13:0] q, be;
    logic [5:0]  fb;
    logic [11:0] emax;
    kp = keep3_r; q = q3_r; mg = '0;
    fb = dbl3_r ? 6'd52 : 6'd23;
    emax = dbl3_r ? 12'd2047 : 12'd255;
    if ((kp >> (fb + 6'd1)) != 0) begin
      kp = kp >> 1; q = q + 14'sd1;
    end
    be = q + 14'($signed({8'd0, fb})) + (dbl3_r ? 14'sd1023 : 14'sd127);
    if ((kp >> fb) != 0) begin
      if (be >= 14'($signed({2'b0, emax}))) mg = {52'd0, emax} << fb;
      else mg = ({50'd0, be} << fb) | (kp & ((64'd1 << fb) - 64'd1));
    end else mg = kp;
    if (k3_r == K_FLT) begin
      if (dbl3_r) res_nxt = {neg3_r, mg[62:0]};
      else res_nxt = {32'd0, neg3_r, mg[30:0]};
    end else res_nxt = fin3_r;
  end

  logic [63:0] res4_r;
  logic        wide4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      res4_r <= res_nxt; wide4_r <= wide3_r;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.result = res4_r;
  assign out_ch.result_is_wide = wide4_r;
endmodule
`default_nettype wire

// ----- sim/conv_tb_ifc.sv -----
`timescale 1ns / 100ps
package conv_tb_pkg;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] operand;
  } conv_req_t;

  typedef struct packed {
    logic [63:0] result;
    logic        wide;
  } conv_res_t;
endpackage

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

  localparam int NumRandom = 1800;
  localparam int StallLimit = 2000;

  // rounds sig * 2^e2 to a format with fb fraction bits; magnitude only
  function automatic logic [63:0] round_to_fmt(logic [63:0] sig, int e2, int fb, int bias,
                                               int emaxf);
    int p, e, q, sh, be;
    logic [63:0] keep, rem, half;
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    e = p + e2;
    q = ((e > 1 - bias) ? e : 1 - bias) - fb;
    sh = q - e2;
    if (sh <= 0) keep = sig << (-sh);
    else if (sh >= 65) keep = '0;
    else if (sh == 64) keep = (sig > (64'd1 << 63)) ? 64'd1 : 64'd0;
    else begin
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      keep = sig >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    if ((keep >> (fb + 1)) != 0) begin
      keep >>= 1;
      q++;
    end
    if ((keep >> fb) != 0) begin
      be = q + fb + bias;
      if (be >= emaxf) return 64'(emaxf) << fb;
      return (64'(be) << fb) | (keep - (64'd1 << fb));
    end
    return keep;
  endfunction

  function automatic logic [63:0] int_to_fp(logic [63:0] v, bit is64, bit dbl);
    logic neg;
    logic [63:0] mag;
    neg = is64 ? v[63] : v[31];
    mag = neg ? -v : v;
    if (!is64) mag &= 64'hFFFF_FFFF;
    if (mag == 0) return '0;
    if (dbl) return {neg, 63'd0} | round_to_fmt(mag, 0, 52, 1023, 2047);
    return {32'd0, neg, 31'd0} | round_to_fmt(mag, 0, 23, 127, 255);
  endfunction

  // splits a float; returns 0 for nan or infinity
  function automatic bit split_fp(logic [63:0] b, bit dbl, output logic neg,
                                  output logic [63:0] sig, output int e2,
                                  output logic [63:0] frac, output bit nan);
    int fb, bias;
    logic [63:0] emask, ex;
    fb = dbl ? 52 : 23;
    bias = dbl ? 1023 : 127;
    emask = dbl ? 64'h7FF : 64'hFF;
    ex = (b >> fb) & emask;
    frac = b & ((64'd1 << fb) - 64'd1);
    neg = dbl ? b[63] : b[31];
    nan = (ex == emask) && frac != 0;
    sig = '0;
    e2 = 0;
    if (ex == emask) return 1'b0;
    if (ex == 0) begin
      sig = frac;
      e2 = 1 - bias - fb;
    end else begin
      sig = frac | (64'd1 << fb);
      e2 = int'(ex) - bias - fb;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] fp_to_int(logic [63:0] b, bit dbl, bit to64);
    logic neg;
    bit nan;
    logic [63:0] sig, frac, mag, minv, limit, mask;
    int e2;
    minv = to64 ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    mask = to64 ? '1 : 64'hFFFF_FFFF;
    if (!split_fp(b, dbl, neg, sig, e2, frac, nan)) return minv;
    limit = neg ? minv : minv - 64'd1;
    if (e2 >= 0) begin
      if (e2 >= 64 || sig > (limit >> e2)) return minv;
      mag = sig << e2;
    end else mag = (-e2 >= 64) ? 64'd0 : (sig >> (-e2));
    if (mag > limit) return minv;
    return (neg ? -mag : mag) & mask;
  endfunction

  function automatic logic [63:0] fp_resize(logic [63:0] b, bit from_dbl);
    logic neg;
    bit nan;
    logic [63:0] sig, frac, s;
    int e2;
    bit fin;
    fin = split_fp(b, from_dbl, neg, sig, e2, frac, nan);
    if (!from_dbl) begin
      s = {neg, 63'd0};
      if (!fin) return nan ? (s | 64'h7FF8_0000_0000_0000 | (frac << 29))
                           : (s | 64'h7FF0_0000_0000_0000);
      if (sig == 0) return s;
      return s | round_to_fmt(sig, e2, 52, 1023, 2047);
    end
    s = {32'd0, neg, 31'd0};
    if (!fin) return nan ? (s | 64'h7FC0_0000 | (frac >> 29)) : (s | 64'h7F80_0000);
    if (sig == 0) return s;
    return s | round_to_fmt(sig, e2, 23, 127, 255);
  endfunction

  function automatic logic [63:0] sign_ext(logic [63:0] v, int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    v &= (m << 1) - 64'd1;
    return (v ^ m) - m;
  endfunction

  function automatic conv_tb_pkg::conv_res_t convert(conv_tb_pkg::conv_req_t w);
    conv_tb_pkg::conv_res_t r;
    logic [63:0] lo;
    lo = {32'd0, w.operand[31:0]};
    r = '0;
    case (w.opcode)
      ifc_pkg::OP_I32_I8:  r.result = sign_ext(lo, 8) & 64'hFFFF_FFFF;
      ifc_pkg::OP_I32_I16: r.result = sign_ext(lo, 16) & 64'hFFFF_FFFF;
      ifc_pkg::OP_I32_I64: begin r.result = sign_ext(lo, 32); r.wide = 1'b1; end
      ifc_pkg::OP_I32_F32: r.result = int_to_fp(lo, 1'b0, 1'b0);
      ifc_pkg::OP_I32_F64: begin r.result = int_to_fp(lo, 1'b0, 1'b1); r.wide = 1'b1; end
      ifc_pkg::OP_I64_I32: r.result = lo;
      ifc_pkg::OP_I64_F32: r.result = int_to_fp(w.operand, 1'b1, 1'b0);
      ifc_pkg::OP_I64_F64: begin
        r.result = int_to_fp(w.operand, 1'b1, 1'b1); r.wide = 1'b1;
      end
      ifc_pkg::OP_F32_I32: r.result = fp_to_int(lo, 1'b0, 1'b0);
      ifc_pkg::OP_F32_I64: begin r.result = fp_to_int(lo, 1'b0, 1'b1); r.wide = 1'b1; end
      ifc_pkg::OP_F32_F64: begin r.result = fp_resize(lo, 1'b0); r.wide = 1'b1; end
      ifc_pkg::OP_F64_I32: r.result = fp_to_int(w.operand, 1'b1, 1'b0);
      ifc_pkg::OP_F64_I64: begin
        r.result = fp_to_int(w.operand, 1'b1, 1'b1); r.wide = 1'b1;
      end
      ifc_pkg::OP_F64_F32: r.result = fp_resize(w.operand, 1'b1);
      default: r = '0;
    endcase
    return r;
  endfunction

  class conv_scoreboard;
    conv_tb_pkg::conv_res_t pending[$];
    int mismatches;

    function void note_word(conv_tb_pkg::conv_req_t w);
      pending.push_back(convert(w));
    endfunction

    function void check_word(conv_tb_pkg::conv_res_t got);
      conv_tb_pkg::conv_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h wide %b", got.result, got.wide);
        return;
      end
      want = pending.pop_front();
      if (got.result !== want.result || got.wide !== want.wide) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h wide %b, got %h wide %b",
                   want.result, want.wide, got.result, got.wide);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  ifc_in_if in_ch();
  ifc_out_if out_ch();
  conv_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;
  conv_tb_pkg::conv_req_t stim[$];

  int_float_conversion_unit i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = '0;
    in_ch.operand = '0;
    out_ch.ready = 0;
  end

  // sample at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_word({in_ch.opcode, in_ch.operand});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.result, out_ch.result_is_wide});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        out_ch.ready <= 0;
        repeat (burst) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(negedge clk);
    end
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v[62:52] = 11'(1023 + $urandom_range(0, 70)) - 11'd6;
      1: v[30:23] = 8'(127 + $urandom_range(0, 70)) - 8'd6;
      2: v[62:52] = 11'(896 + $urandom_range(0, 60)) - 11'd30;
      3: v = sign_ext(v, $urandom_range(1, 64));
      4: v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      5: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(conv_tb_pkg::conv_req_t w);
    int burst;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 13);
      in_ch.valid <= 0;
      repeat (burst) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= w.opcode;
    in_ch.operand <= w.operand;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [63:0] edges[$];
    edges = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
              64'h0000_0000_8000_0000, 64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0000,
              64'h47EF_FFFF_F000_0000, 64'h0000_0000_7F80_0001, 64'h0000_0000_4F00_0000,
              64'h41E0_0000_0000_0000, 64'hC3E0_0000_0000_0000, 64'h3810_0000_0000_0000};
    foreach (edges[k]) for (int op = 0; op < 16; op += 3) stim.push_back({4'(op), edges[k]});
    for (int op = 0; op < 16; op++) stim.push_back({4'(op), {$urandom, $urandom}});
    for (int k = 0; k < NumRandom; k++)
      stim.push_back({4'($urandom_range(0, 15) == 0 ? $urandom_range(14, 15)
                                                    : $urandom_range(0, 13)), rand_operand()});
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    foreach (stim[k]) begin
      if (k > stim.size() - 150) quiet = 1;
      send_word(stim[k]);
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/ifc_pkg.sv
hw/rtl/ifc_if.sv
hw/rtl/ifc_lzc.sv
hw/rtl/int_float_conversion_unit.sv
sim/conv_tb_ifc.sv
sim/testbench.sv
